// ===== rtl/core/lsac_pkg.sv =====
// lsac_pkg: shared constants, codes and types of the lru set-associative cache core
// used by every interface and module of the block; depends on nothing
`timescale 1ns / 1ps

package lsac_pkg;

  localparam int MAX_SET_BITS = 8;
  localparam int SET_W        = MAX_SET_BITS;
  localparam int SET_COUNT    = 1 << MAX_SET_BITS;
  localparam int WAYS         = 8;
  localparam int WAY_W        = 3;
  localparam int RANK_W       = 3;
  localparam int ADDR_W       = 64;
  localparam int CNT_W        = 32;
  localparam int SB_W         = 4;
  localparam int BB_W         = 6;
  localparam int NW_W         = 4;
  localparam int SHIFT_W      = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  // access kinds
  localparam logic [1:0] FUNC_INSTR  = 2'd0;
  localparam logic [1:0] FUNC_LOAD   = 2'd1;
  localparam logic [1:0] FUNC_STORE  = 2'd2;
  localparam logic [1:0] FUNC_MODIFY = 2'd3;

  // access outcomes
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  typedef logic [WAYS-1:0][ADDR_W-1:0] tag_row_t;

  typedef struct packed {
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0][RANK_W-1:0] rank;
  } meta_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic [WAY_W-1:0] way;
    meta_t            meta_nxt;
  } decision_t;

endpackage

// ===== rtl/core/lsac_in_if.sv =====
// lsac_in_if: access channel into the cache core (valid, ready, func, address)
// depends on lsac_pkg
`timescale 1ns / 1ps

interface lsac_in_if;
  import lsac_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output func, output address, input ready);
  modport sink   (input valid, input func, input address, output ready);
endinterface

// ===== rtl/core/lsac_out_if.sv =====
// lsac_out_if: result channel out of the cache core (valid, ready, outcome, totals, last)
// depends on lsac_pkg
`timescale 1ns / 1ps

interface lsac_out_if;
  import lsac_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       outcome;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] eviction_total;
  logic             last;

  modport source (output valid, output outcome, output hit_total, output miss_total,
                  output eviction_total, output last, input ready);
  modport sink   (input valid, input outcome, input hit_total, input miss_total,
                  input eviction_total, input last, output ready);
endinterface

// ===== rtl/core/lsac_cfg_if.sv =====
// lsac_cfg_if: configuration write channel of the cache core (valid, ready, index, data)
// depends on lsac_pkg
`timescale 1ns / 1ps

interface lsac_cfg_if;
  import lsac_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/lru_set_assoc_cache_sim_core.sv =====
// lru_set_assoc_cache_sim_core: top level of the lru set-associative cache tag store
// depends on lsac_pkg, lsac_in_if, lsac_out_if, lsac_cfg_if and lsac_way_select
`timescale 1ns / 1ps

// usage
// - in_ch takes one transaction (func, address) when valid and ready are high; ready is
//   high only while the sequencer is idle
// - out_ch gives one transaction per access: outcome and the running hit, miss and
//   eviction totals after it; last marks the final one of an input
// - cfg_ch is always ready; write set_bits, block_bits or ways_in_use only while idle
// - an instruction fetch is taken and gives nothing
// - load or store: one shared lookup pass = accept (registered set row read) plus a lookup
//   state; the result is valid the cycle after the lookup retires
// - modify: the lookup pass runs twice on the same set, with a re-read state between;
//   the re-read is there because the registered set row read has to pick up the row
//   written by the first pass
// - a finished result sits in the output register; if the receiver stalls, the next
//   lookup waits in its lookup cycle until that register frees
// - reset clears the counters, the sequencer and one valid bit per set row; a row whose
//   bit is clear reads as all ways invalid with zero ranks, so no clearing pass runs
module lru_set_assoc_cache_sim_core (
  input  logic        clk,
  input  logic        rst_n,
  lsac_in_if.sink     in_ch,
  lsac_out_if.source  out_ch,
  lsac_cfg_if.sink    cfg_ch
);
  import lsac_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_LK   = 2'd2;

  // sequencer
  logic [1:0]        state_r, state_nxt;
  logic              second_r, second_nxt;
  logic [1:0]        func_r;
  logic [ADDR_W-1:0] addr_r;

  // configuration
  logic [SB_W-1:0] set_bits_r;
  logic [BB_W-1:0] block_bits_r;
  logic [NW_W-1:0] ways_r;

  // set row storage
  tag_row_t             tag_mem [SET_COUNT];
  meta_t                meta_mem [SET_COUNT];
  logic [SET_COUNT-1:0] row_vld_r;

  // registered read of the addressed set
  tag_row_t          rd_tags_r;
  meta_t             rd_meta_r;
  logic              rd_rowv_r;
  logic [SET_W-1:0]  set_r;
  logic [ADDR_W-1:0] tag_r;

  // counters and output register
  logic [CNT_W-1:0] hit_cnt_r, miss_cnt_r, ev_cnt_r;
  logic [CNT_W-1:0] hit_nxt, miss_nxt, ev_nxt;
  logic             out_valid_r;
  logic [1:0]       out_outcome_r;
  logic             out_last_r;

  // address decode
  logic              in_acc;
  logic              rd_en;
  logic [ADDR_W-1:0] dec_addr;
  logic [SB_W-1:0]   sb_eff;
  logic [NW_W-1:0]   nw_eff;
  logic [SHIFT_W-1:0] tshift;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  dec_set;
  logic [ADDR_W-1:0] dec_tag;

  // lookup
  meta_t     cur_meta;
  decision_t dec;
  tag_row_t  tags_wr;
  logic      lk_fire;
  logic      last_acc;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // clamp the configuration to the built geometry
  assign sb_eff = (set_bits_r > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS) : set_bits_r;
  assign nw_eff = (ways_r == '0) ? NW_W'(1) :
                  ((ways_r > NW_W'(WAYS)) ? NW_W'(WAYS) : ways_r);

  // first access decodes the port address, the second one the held copy
  assign dec_addr = (state_r == S_IDLE) ? in_ch.address : addr_r;
  assign rd_en    = in_acc || (state_r == S_RD);
  assign tshift   = SHIFT_W'(sb_eff) + SHIFT_W'(block_bits_r);
  assign set_mask = ~({SET_W{1'b1}} << sb_eff);
  assign dec_set  = SET_W'(dec_addr >> block_bits_r) & set_mask;
  assign dec_tag  = (tshift >= SHIFT_W'(ADDR_W)) ? '0 : (dec_addr >> tshift);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= SB_W'(1);
      block_bits_r <= BB_W'(1);
      ways_r       <= NW_W'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_SET_BITS:   set_bits_r   <= cfg_ch.data[SB_W-1:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_ch.data[BB_W-1:0];
        CFG_WAYS:       ways_r       <= cfg_ch.data[NW_W-1:0];
        default: ;
      endcase
    end
  end

  // set row memories: one read and one write port, read data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tags_r <= tag_mem[dec_set];
      rd_meta_r <= meta_mem[dec_set];
      rd_rowv_r <= row_vld_r[dec_set];
      set_r     <= dec_set;
      tag_r     <= dec_tag;
    end
    if (lk_fire) begin
      tag_mem[set_r]  <= tags_wr;
      meta_mem[set_r] <= dec.meta_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (lk_fire) begin
      row_vld_r[set_r] <= 1'b1;
    end
  end

  // a never-written row reads as all invalid with zero ranks
  assign cur_meta = rd_rowv_r ? rd_meta_r : '0;

  lsac_way_select u_way_select (
    .meta (cur_meta),
    .tags (rd_tags_r),
    .tag  (tag_r),
    .nw   (nw_eff),
    .dec  (dec)
  );

  always_comb begin
    tags_wr          = rd_tags_r;
    tags_wr[dec.way] = tag_r;
  end

  // lookup retires only when the output register can take its result
  assign lk_fire  = (state_r == S_LK) && (!out_valid_r || out_ch.ready);
  assign last_acc = (func_r != FUNC_MODIFY) || second_r;

  always_comb begin
    hit_nxt  = hit_cnt_r;
    miss_nxt = miss_cnt_r;
    ev_nxt   = ev_cnt_r;
    if (dec.outcome == OUT_HIT) begin
      if (hit_cnt_r != '1) hit_nxt = hit_cnt_r + 1'b1;
    end else begin
      if (miss_cnt_r != '1) miss_nxt = miss_cnt_r + 1'b1;
      if (dec.outcome == OUT_EVICT && ev_cnt_r != '1) ev_nxt = ev_cnt_r + 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.func != FUNC_INSTR) begin
          state_nxt  = S_LK;
          second_nxt = 1'b0;
        end
      end
      S_RD: begin
        state_nxt = S_LK;
      end
      S_LK: begin
        if (lk_fire) begin
          if (last_acc) begin
            state_nxt  = S_IDLE;
            second_nxt = 1'b0;
          end else begin
            state_nxt  = S_RD;
            second_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt  = S_IDLE;
        second_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      second_r    <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      ev_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
      if (lk_fire) begin
        hit_cnt_r   <= hit_nxt;
        miss_cnt_r  <= miss_nxt;
        ev_cnt_r    <= ev_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_ch.func;
      addr_r <= in_ch.address;
    end
    if (lk_fire) begin
      out_outcome_r <= dec.outcome;
      out_last_r    <= last_acc;
    end
  end

  // totals in the output register mirror the counters
  assign out_ch.valid          = out_valid_r;
  assign out_ch.outcome        = out_outcome_r;
  assign out_ch.hit_total      = hit_cnt_r;
  assign out_ch.miss_total     = miss_cnt_r;
  assign out_ch.eviction_total = ev_cnt_r;
  assign out_ch.last           = out_last_r;

  // every eviction is also a miss
  a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
    ev_cnt_r <= miss_cnt_r)
    else $error("eviction total exceeds miss total");

  // a second access belongs to a modify only
  a_second_modify: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> func_r == FUNC_MODIFY)
    else $error("second access without modify");

  // a new result appears only after a lookup cycle
  a_out_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_LK)
    else $error("result without lookup");

  // a hit bumps the hit counter unless saturated
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    lk_fire && dec.outcome == OUT_HIT |=>
      hit_cnt_r == $past(hit_cnt_r) + 1'b1 || $past(hit_cnt_r) == '1)
    else $error("hit counter not advanced");

  // the touched way is left valid and most recent
  a_touched_valid: assert property (@(posedge clk) disable iff (!rst_n)
    lk_fire |-> dec.meta_nxt.valid[dec.way] && dec.meta_nxt.rank[dec.way] == '0)
    else $error("touched way not most recent");

endmodule

// ===== rtl/core/lsac_way_select.sv =====
// lsac_way_select: hit search, free-way search, lru victim pick and rank update for one set
// depends on lsac_pkg
`timescale 1ns / 1ps

module lsac_way_select (
  input  lsac_pkg::meta_t         meta,
  input  lsac_pkg::tag_row_t      tags,
  input  logic [lsac_pkg::ADDR_W-1:0] tag,
  input  logic [lsac_pkg::NW_W-1:0]   nw,
  output lsac_pkg::decision_t     dec
);
  import lsac_pkg::*;

  logic             hit_found;
  logic [WAY_W-1:0] hit_way;
  logic             free_found;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] sel;
  logic             was_valid;
  logic [RANK_W:0]  old_rank;

  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    // descending scan so the lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (NW_W'(w) < nw) begin
        if (meta.valid[w] && tags[w] == tag) begin
          hit_found = 1'b1;
          hit_way   = WAY_W'(w);
        end
        if (!meta.valid[w]) begin
          free_found = 1'b1;
          free_way   = WAY_W'(w);
        end
      end
    end
    // oldest in-use way, lowest on a tie
    victim = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (NW_W'(w) < nw && meta.rank[w] > meta.rank[victim]) begin
        victim = WAY_W'(w);
      end
    end
  end

  always_comb begin
    if (hit_found) begin
      sel         = hit_way;
      was_valid   = 1'b1;
      dec.outcome = OUT_HIT;
    end else if (free_found) begin
      sel         = free_way;
      was_valid   = 1'b0;
      dec.outcome = OUT_FILL;
    end else begin
      sel         = victim;
      was_valid   = 1'b1;
      dec.outcome = OUT_EVICT;
    end
    old_rank = was_valid ? {1'b0, meta.rank[sel]} : (RANK_W + 1)'(WAYS);
    dec.way  = sel;
    dec.meta_nxt = meta;
    // age the valid lines younger than the touched one
    for (int v = 0; v < WAYS; v++) begin
      if (WAY_W'(v) != sel && meta.valid[v] && {1'b0, meta.rank[v]} < old_rank &&
          meta.rank[v] != {RANK_W{1'b1}}) begin
        dec.meta_nxt.rank[v] = meta.rank[v] + 1'b1;
      end
    end
    dec.meta_nxt.rank[sel]  = '0;
    dec.meta_nxt.valid[sel] = 1'b1;
  end

endmodule
